>>> src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pdtq_pkg.sv
package pdtq_pkg;

    // function codes on the input tuser
    localparam logic [1:0] FN_INIT   = 2'd0;
    localparam logic [1:0] FN_UPDATE = 2'd1;
    localparam logic [1:0] FN_QUERY  = 2'd2;

    // action codes on the output tuser
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_LOCAL = 2'd1;
    localparam logic [1:0] ACT_IPI   = 2'd2;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 80;

    localparam logic [63:0] DL_NONE = 64'hFFFF_FFFF_FFFF_FFFF;

    // input tdata bit positions
    localparam int IN_SRC_LSB    = 0;
    localparam int IN_DL_LSB     = 5;
    localparam int IN_TYPE_LSB   = 69;
    localparam int IN_CPU_LSB    = 73;
    localparam int IN_CALLER_LSB = 81;

    // output tdata bit positions
    localparam int OUT_ES_LSB    = 64;
    localparam int OUT_EMPTY_BIT = 69;
    localparam int OUT_TGT_LSB   = 70;

    typedef struct packed {
        logic [63:0] deadline;
        logic [7:0]  owner;
        logic [3:0]  kind;
    } t_src_ent;

endpackage

>>> src/per_cpu_deadline_timer_queue_unit.sv
// Per-CPU earliest-deadline timer queue.
// Input stream (s_axis): one beat is one request; tuser carries the function
// (init, update, query), tdata the source, deadline, type, cpu and caller.
// Output stream (m_axis): exactly one beat per request with the reported
// queue's earliest deadline, its source, an empty flag and the target cpu;
// tuser carries the action (none, program local timer, send IPI).
// Configuration: i_cfg_we writes the cpu count from i_cfg_wdata; the user must
// do so only while idle, as the block itself does not enforce it.
// A query, an unchanged update or an init of a disarmed source steps through
// the read, decode, cache-read and report states, then back to idle.
// An update that changes something, or an init of an armed source, also
// rescans the whole source table through one shared 64-bit comparator, one
// entry per cycle, and writes the per-cpu cache before its cache read.
// One request is in flight at a time: tready is high only when the
// sequencer is idle and reset is released.
// Reset clears the armed bits, the per-cpu cache valid bits (every cpu then
// reads as empty) and sets the cpu count to 1; the source table is not cleared.
// A stalled receiver keeps the result in the output register; the next
// request may be accepted meanwhile and waits at its report step.
module per_cpu_deadline_timer_queue_unit
    import pdtq_pkg::*;
#(
    parameter int SOURCES = 32,
    parameter int CPUS    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // source[4:0], deadline[68:5], source_type[72:69], cpu[80:73],
    // caller_cpu[83:81], zero pad[87:84]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // func[1:0]
    input  logic [1:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // next_ns[63:0], earliest_source[68:64], queue_empty[69],
    // target_cpu[72:70], zero pad[79:73]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // action[1:0]
    output logic [1:0]            o_m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [3:0]            i_cfg_wdata
);

    localparam int SRC_W = $clog2(SOURCES);
    localparam int CPU_W = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam logic [10:0] SRC_LIM = 11'(SOURCES);
    localparam logic [8:0]  CPU_LIM = 9'(CPUS);
    localparam logic [SRC_W-1:0] SRC_LAST = SRC_W'(SOURCES - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_DEC  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_WR   = 3'd4;
    localparam logic [2:0] ST_RQ   = 3'd5;
    localparam logic [2:0] ST_RSP  = 3'd6;

    function automatic logic [CPU_W-1:0] queue_of(input logic [7:0] c);
        queue_of = (9'(c) < CPU_LIM) ? CPU_W'(c) : '0;
    endfunction

    // memories
    t_src_ent          r_src_mem [SOURCES];
    logic [63:0]       r_cpu_next_mem [CPUS];
    logic [SRC_W-1:0]  r_cpu_first_mem [CPUS];

    logic [2:0]        r_state, n_state;
    logic [3:0]        r_cpu_count;
    logic [SOURCES-1:0] r_armed;
    logic [CPUS-1:0]   r_cpu_vld;

    // latched request
    logic [1:0]        r_func;
    logic              r_s_ok;
    logic [SRC_W-1:0]  r_src;
    logic [63:0]       r_dl;
    logic [3:0]        r_type;
    logic [7:0]        r_cpu;
    logic [2:0]        r_caller;

    // read data
    t_src_ent          r_src_rd;
    logic [63:0]       r_cpu_rd_next;
    logic [SRC_W-1:0]  r_cpu_rd_first;
    logic              r_cpu_rd_vld;

    // scan
    logic [CPU_W-1:0]  r_qs;
    logic [7:0]        r_owner;
    logic [SRC_W-1:0]  r_idx;
    logic              r_issuing;
    logic              r_pv;
    logic              r_p_last;
    logic              r_p_arm;
    logic [SRC_W-1:0]  r_p_idx;
    logic              r_first_cyc;
    logic              r_found;
    logic [63:0]       r_bd;
    logic [3:0]        r_bk;
    logic [SRC_W-1:0]  r_bi;
    logic [63:0]       r_old_next;

    logic [CPU_W-1:0]  r_rq;
    logic [1:0]        r_act;

    // output register
    logic              r_m_valid;
    logic [63:0]       r_m_next;
    logic [4:0]        r_m_es;
    logic              r_m_empty;
    logic [2:0]        r_m_tgt;
    logic [1:0]        r_m_act;

    logic              c_acc;
    logic              c_src_we;
    logic [SRC_W-1:0]  c_src_wa;
    t_src_ent          c_src_wd;
    logic              c_src_re;
    logic [SRC_W-1:0]  c_src_ra;
    logic              c_cpu_we;
    logic              c_cpu_re;
    logic [CPU_W-1:0]  c_cpu_ra;
    logic [63:0]       c_cpu_next;
    logic [SRC_W-1:0]  c_cpu_first;
    logic              c_armed_new;
    logic              c_cur_armed;
    logic              c_upd_same;
    logic              c_cand;
    logic [63:0]       c_cmp_a;
    logic [63:0]       c_cmp_b;
    logic              c_lt;
    logic              c_eq;
    logic              c_better;
    logic [63:0]       c_new_next;
    logic [SRC_W-1:0]  c_new_first;
    logic              c_is_local;
    logic              c_go;
    logic              c_out_free;

    assign c_acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign c_out_free = !r_m_valid || i_m_axis_tready;

    // effective cache read, an entry never written reads as empty
    assign c_cpu_next  = r_cpu_rd_vld ? r_cpu_rd_next : DL_NONE;
    assign c_cpu_first = r_cpu_rd_vld ? r_cpu_rd_first : '0;

    assign c_armed_new = (r_dl != DL_NONE);
    assign c_cur_armed = r_armed[r_src];
    assign c_upd_same  = (r_src_rd.deadline == r_dl) && (c_cur_armed == c_armed_new);

    assign c_cand = r_pv && r_p_arm && (queue_of(r_src_rd.owner) == r_qs);

    assign c_new_next  = r_found ? r_bd : DL_NONE;
    assign c_new_first = r_found ? r_bi : '0;

    // the one 64-bit comparator: candidate vs best while scanning,
    // new vs old earliest deadline in the write step
    always_comb begin
        if (r_state == ST_WR) begin
            c_cmp_a = c_new_next;
            c_cmp_b = r_old_next;
        end else begin
            c_cmp_a = r_src_rd.deadline;
            c_cmp_b = r_bd;
        end
    end
    assign c_lt = c_cmp_a < c_cmp_b;
    assign c_eq = c_cmp_a == c_cmp_b;
    assign c_better = !r_found || c_lt || (c_eq && (r_src_rd.kind < r_bk));

    assign c_is_local = (r_owner == 8'(r_caller));
    assign c_go = (c_is_local ? !c_eq : c_lt) &&
                  (r_owner < {4'b0, r_cpu_count}) && (9'(r_owner) < CPU_LIM);

    always_comb begin
        n_state     = r_state;
        c_src_we    = 1'b0;
        c_src_wa    = r_src;
        c_src_wd    = '{deadline: DL_NONE, owner: r_cpu, kind: r_type};
        c_src_re    = 1'b0;
        c_src_ra    = r_idx;
        c_cpu_we    = 1'b0;
        c_cpu_re    = 1'b0;
        c_cpu_ra    = r_rq;
        unique case (r_state)
            ST_IDLE: begin
                if (c_acc) begin
                    c_src_re = 1'b1;
                    c_src_ra = SRC_W'(i_s_axis_tdata[IN_SRC_LSB +: 5]);
                    n_state  = ST_RD;
                end
            end
            ST_RD: n_state = ST_DEC;
            ST_DEC: begin
                if (r_s_ok && r_func == FN_INIT) begin
                    c_src_we = 1'b1;
                    n_state  = c_cur_armed ? ST_SCAN : ST_RQ;
                end else if (r_s_ok && r_func == FN_UPDATE && !c_upd_same) begin
                    c_src_we = 1'b1;
                    c_src_wd = '{deadline: r_dl, owner: r_src_rd.owner,
                                 kind: r_src_rd.kind};
                    c_cpu_re = 1'b1;
                    c_cpu_ra = queue_of(r_src_rd.owner);
                    n_state  = ST_SCAN;
                end else begin
                    n_state = ST_RQ;
                end
            end
            ST_SCAN: begin
                c_src_re = r_issuing;
                if (r_pv && r_p_last) begin
                    n_state = ST_WR;
                end
            end
            ST_WR: begin
                c_cpu_we = 1'b1;
                c_cpu_ra = r_qs;
                n_state  = ST_RQ;
            end
            ST_RQ: begin
                c_cpu_re = 1'b1;
                n_state  = ST_RSP;
            end
            ST_RSP: begin
                if (c_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_s_axis_tready = (r_state == ST_IDLE) && i_rst_n;

    // source table
    always_ff @(posedge i_clk) begin
        if (c_src_we) begin
            r_src_mem[c_src_wa] <= c_src_wd;
        end
        if (c_src_re) begin
            r_src_rd <= r_src_mem[c_src_ra];
        end
    end

    // per-cpu cache
    always_ff @(posedge i_clk) begin
        if (c_cpu_we) begin
            r_cpu_next_mem[r_qs]  <= c_new_next;
            r_cpu_first_mem[r_qs] <= c_new_first;
        end
        if (c_cpu_re) begin
            r_cpu_rd_next  <= r_cpu_next_mem[c_cpu_ra];
            r_cpu_rd_first <= r_cpu_first_mem[c_cpu_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cpu_count  <= 4'd1;
            r_armed      <= '0;
            r_cpu_vld    <= '0;
            r_cpu_rd_vld <= 1'b0;
            r_m_valid    <= 1'b0;
            r_pv         <= 1'b0;
            r_issuing    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cpu_count <= i_cfg_wdata;
            end
            if (c_cpu_re) begin
                r_cpu_rd_vld <= r_cpu_vld[c_cpu_ra];
            end
            if (c_cpu_we) begin
                r_cpu_vld[r_qs] <= 1'b1;
            end
            if (r_state == ST_DEC && r_s_ok) begin
                if (r_func == FN_INIT) begin
                    r_armed[r_src] <= 1'b0;
                end else if (r_func == FN_UPDATE) begin
                    r_armed[r_src] <= c_armed_new;
                end
            end
            if (r_state == ST_DEC) begin
                r_issuing <= 1'b1;
                r_pv      <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_pv <= r_issuing;
                if (r_issuing && r_idx == SRC_LAST) begin
                    r_issuing <= 1'b0;
                end
            end else begin
                r_pv      <= 1'b0;
                r_issuing <= 1'b0;
            end
            if (r_state == ST_RSP && c_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // request latch and scan datapath
    always_ff @(posedge i_clk) begin
        if (c_acc) begin
            r_func   <= i_s_axis_tuser;
            r_s_ok   <= 11'(i_s_axis_tdata[IN_SRC_LSB +: 5]) < SRC_LIM;
            r_src    <= SRC_W'(i_s_axis_tdata[IN_SRC_LSB +: 5]);
            r_dl     <= i_s_axis_tdata[IN_DL_LSB +: 64];
            r_type   <= i_s_axis_tdata[IN_TYPE_LSB +: 4];
            r_cpu    <= i_s_axis_tdata[IN_CPU_LSB +: 8];
            r_caller <= i_s_axis_tdata[IN_CALLER_LSB +: 3];
        end
        if (r_state == ST_DEC) begin
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_bd        <= DL_NONE;
            r_bk        <= '0;
            r_bi        <= '0;
            r_first_cyc <= 1'b1;
            r_owner     <= r_src_rd.owner;
            r_qs        <= queue_of(r_src_rd.owner);
            r_act       <= ACT_NONE;
            if (r_s_ok && r_func == FN_UPDATE) begin
                r_rq <= queue_of(r_src_rd.owner);
            end else begin
                r_rq <= queue_of(r_cpu);
            end
        end
        if (r_state == ST_SCAN) begin
            r_first_cyc <= 1'b0;
            if (r_first_cyc) begin
                r_old_next <= c_cpu_next;
            end
            if (r_issuing) begin
                r_idx    <= r_idx + 1'b1;
                r_p_arm  <= r_armed[r_idx];
                r_p_idx  <= r_idx;
                r_p_last <= (r_idx == SRC_LAST);
            end
            if (c_cand && c_better) begin
                r_found <= 1'b1;
                r_bd    <= r_src_rd.deadline;
                r_bk    <= r_src_rd.kind;
                r_bi    <= r_p_idx;
            end
        end
        if (r_state == ST_WR && r_func == FN_UPDATE && c_go) begin
            r_act <= c_is_local ? ACT_LOCAL : ACT_IPI;
        end
        if (r_state == ST_RSP && c_out_free) begin
            r_m_next  <= c_cpu_next;
            r_m_es    <= 5'(c_cpu_first);
            r_m_empty <= (c_cpu_next == DL_NONE);
            r_m_tgt   <= 3'(r_rq);
            r_m_act   <= r_act;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {7'd0, r_m_tgt, r_m_empty, r_m_es, r_m_next};
    assign o_m_axis_tuser  = r_m_act;

endmodule

>>> src/pdtq_checker.sv
`include "assert_macros.svh"

module pdtq_checker
    import pdtq_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [1:0]            o_m_axis_tuser
);

    logic                  c_in_acc;
    logic                  c_stall;
    logic                  c_vld;
    logic [OUT_DATA_W+1:0] c_beat;
    logic                  c_empty;
    logic                  c_empty_ok;
    logic                  c_es_zero;
    logic                  c_act_ok;

    assign c_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign c_stall    = o_m_axis_tvalid && !i_m_axis_tready;
    assign c_vld      = o_m_axis_tvalid;
    assign c_beat     = {o_m_axis_tuser, o_m_axis_tdata};
    assign c_empty    = o_m_axis_tdata[OUT_EMPTY_BIT];
    assign c_empty_ok = (c_empty == (o_m_axis_tdata[63:0] == DL_NONE));
    assign c_es_zero  = (o_m_axis_tdata[OUT_ES_LSB +: 5] == 5'd0);
    assign c_act_ok   = (o_m_axis_tuser == ACT_NONE) || (o_m_axis_tuser == ACT_LOCAL) ||
                        (o_m_axis_tuser == ACT_IPI);

    // a stalled result beat holds
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, c_stall, c_vld && $stable(c_beat), "beat moved in stall")

    // one request at a time
    `ASSERT_NEXT(a_busy, i_clk, i_rst_n, c_in_acc, !o_s_axis_tready, "accepted while busy")

    // empty flag matches the all-ones deadline
    `ASSERT_SAME(a_empty, i_clk, i_rst_n, c_vld, c_empty_ok, "empty flag disagrees with next_ns")

    // an empty queue reports source zero
    `ASSERT_SAME(a_empty_src, i_clk, i_rst_n, c_vld && c_empty, c_es_zero, "empty queue with a source")

    // no reserved action code
    `ASSERT_SAME(a_act, i_clk, i_rst_n, c_vld, c_act_ok, "reserved action code")

endmodule

bind per_cpu_deadline_timer_queue_unit pdtq_checker u_pdtq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

>>> dv/per_cpu_deadline_timer_queue_unit_tb.sv
module per_cpu_deadline_timer_queue_unit_tb;
    import pdtq_pkg::*;

    // func 3 is not decoded by the block and behaves as a query
    localparam logic [1:0] FN_SPARE = 2'd3;

    localparam int NSRC        = 32;
    localparam int NCPU        = 8;
    localparam int PHASE_ITEMS = 386;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 45;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]  fn;
        logic [4:0]  src;
        logic [63:0] dl;
        logic [3:0]  kind;
        logic [7:0]  cpu;
        logic [2:0]  caller;
    } t_tq_req;

    typedef struct packed {
        logic [63:0] next_ns;
        logic [4:0]  first_src;
        logic        empty;
        logic [1:0]  act;
        logic [2:0]  tgt;
    } t_tq_report;

    typedef struct packed {
        t_tq_req    req;
        logic       typed;
        t_tq_report rep;
    } t_step_row;

    localparam t_tq_report NO_REP = '0;
    localparam logic [63:0] AS = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [63:0] FIVES = 64'h5555_5555_5555_5555;

    localparam t_step_row STEPS [23] = '{
        // empty queues straight after reset, cpu 255 folds onto queue 0
        '{'{FN_QUERY, 5'd0, 64'd0, 4'd0, 8'd0, 3'd0}, 1'b1,
          '{DL_NONE, 5'd0, 1'b1, ACT_NONE, 3'd0}},
        '{'{FN_QUERY, 5'd31, DL_NONE, 4'd15, 8'd255, 3'd7}, 1'b1,
          '{DL_NONE, 5'd0, 1'b1, ACT_NONE, 3'd0}},
        '{'{FN_SPARE, 5'd0, 64'd0, 4'd0, 8'd7, 3'd0}, 1'b1,
          '{DL_NONE, 5'd0, 1'b1, ACT_NONE, 3'd7}},
        '{'{FN_INIT, 5'd0, 64'd0, 4'd5, 8'd0, 3'd0}, 1'b1,
          '{DL_NONE, 5'd0, 1'b1, ACT_NONE, 3'd0}},
        '{'{FN_INIT, 5'd31, 64'd0, 4'd15, 8'd0, 3'd7}, 1'b1,
          '{DL_NONE, 5'd0, 1'b1, ACT_NONE, 3'd0}},
        '{'{FN_UPDATE, 5'd0, 64'd100, 4'd0, 8'd0, 3'd0}, 1'b1,
          '{64'd100, 5'd0, 1'b0, ACT_LOCAL, 3'd0}},
        // equal deadline, higher type loses the tie
        '{'{FN_UPDATE, 5'd31, 64'd100, 4'd0, 8'd0, 3'd3}, 1'b0, NO_REP},
        '{'{FN_UPDATE, 5'd31, 64'd0, 4'd0, 8'd0, 3'd3}, 1'b1,
          '{64'd0, 5'd31, 1'b0, ACT_IPI, 3'd0}},
        // same deadline again: nothing changes
        '{'{FN_UPDATE, 5'd31, 64'd0, 4'd0, 8'd0, 3'd0}, 1'b1,
          '{64'd0, 5'd31, 1'b0, ACT_NONE, 3'd0}},
        '{'{FN_INIT, 5'd1, 64'd0, 4'd0, 8'd200, 3'd0}, 1'b1,
          '{64'd0, 5'd31, 1'b0, ACT_NONE, 3'd0}},
        '{'{FN_UPDATE, 5'd1, 64'd0, 4'd0, 8'd0, 3'd0}, 1'b0, NO_REP},
        '{'{FN_UPDATE, 5'd31, DL_NONE, 4'd0, 8'd0, 3'd0}, 1'b0, NO_REP},
        // init of an armed source pulls it out of its old queue
        '{'{FN_INIT, 5'd1, 64'd0, 4'd2, 8'd3, 3'd3}, 1'b0, NO_REP},
        '{'{FN_QUERY, 5'd0, 64'd0, 4'd0, 8'd0, 3'd0}, 1'b0, NO_REP},
        '{'{FN_INIT, 5'd2, 64'd0, 4'd0, 8'd0, 3'd3}, 1'b0, NO_REP},
        // owner above cpu_count: queue moves but no reprogram
        '{'{FN_UPDATE, 5'd1, DL_NONE - 64'd1, 4'd0, 8'd0, 3'd3}, 1'b0, NO_REP},
        '{'{FN_UPDATE, 5'd2, 64'd100, 4'd0, 8'd0, 3'd0}, 1'b0, NO_REP},
        '{'{FN_UPDATE, 5'd2, 64'd50, 4'd0, 8'd0, 3'd0}, 1'b0, NO_REP},
        '{'{FN_UPDATE, 5'd2, AS, 4'd0, 8'd0, 3'd5}, 1'b0, NO_REP},
        '{'{FN_UPDATE, 5'd2, FIVES, 4'd0, 8'd0, 3'd0}, 1'b0, NO_REP},
        '{'{FN_UPDATE, 5'd0, DL_NONE, 4'd0, 8'd0, 3'd0}, 1'b0, NO_REP},
        '{'{FN_UPDATE, 5'd2, DL_NONE, 4'd0, 8'd0, 3'd0}, 1'b0, NO_REP},
        '{'{FN_QUERY, 5'd0, 64'd0, 4'd0, 8'd3, 3'd3}, 1'b0, NO_REP}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_we;
    logic [3:0]            cfg_wdata;

    // shadow of the block's table and per-cpu cache
    logic [63:0] src_dl    [NSRC];
    logic [7:0]  src_owner [NSRC];
    logic [3:0]  src_kind  [NSRC];
    logic        src_on    [NSRC];
    logic        src_bound [NSRC];
    logic [63:0] q_next    [NCPU];
    logic [4:0]  q_first   [NCPU];
    logic [3:0]  cpus_present;

    t_tq_report awaited_reports [$];
    int         mismatches;
    int         quiet_cycles;
    bit         no_gaps;
    bit         hold_off;

    per_cpu_deadline_timer_queue_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [2:0] queue_of(input logic [7:0] c);
        return (c < NCPU) ? c[2:0] : 3'd0;
    endfunction

    function automatic void rescan_queue(input logic [2:0] q);
        logic        found;
        logic [63:0] best_dl;
        logic [3:0]  best_kind;
        logic [4:0]  best_idx;
        found = 1'b0;
        best_dl = DL_NONE;
        best_kind = '0;
        best_idx = '0;
        for (int i = 0; i < NSRC; i++) begin
            if (src_on[i] && queue_of(src_owner[i]) == q) begin
                if (!found || src_dl[i] < best_dl ||
                    (src_dl[i] == best_dl && src_kind[i] < best_kind)) begin
                    found = 1'b1;
                    best_dl = src_dl[i];
                    best_kind = src_kind[i];
                    best_idx = 5'(i);
                end
            end
        end
        q_next[q] = found ? best_dl : DL_NONE;
        q_first[q] = found ? best_idx : 5'd0;
    endfunction

    // applies one request to the shadow state and returns the beat it should produce
    function automatic t_tq_report queue_report_for(input t_tq_req r);
        logic [2:0]  q;
        logic [63:0] was;
        logic        arm;
        logic        go;
        logic [1:0]  act;
        t_tq_report  rep;
        act = ACT_NONE;
        q = queue_of(r.cpu);
        if (r.fn == FN_INIT) begin
            if (src_on[r.src]) begin
                src_on[r.src] = 1'b0;
                rescan_queue(queue_of(src_owner[r.src]));
            end
            src_dl[r.src] = DL_NONE;
            src_owner[r.src] = r.cpu;
            src_kind[r.src] = r.kind;
        end else if (r.fn == FN_UPDATE) begin
            q = queue_of(src_owner[r.src]);
            arm = (r.dl != DL_NONE);
            if (!(src_dl[r.src] == r.dl && src_on[r.src] == arm)) begin
                was = q_next[q];
                src_dl[r.src] = r.dl;
                src_on[r.src] = arm;
                rescan_queue(q);
                if (src_owner[r.src] == {5'd0, r.caller})
                    go = (q_next[q] != was);
                else
                    go = (q_next[q] < was);
                if (go && src_owner[r.src] < {4'd0, cpus_present} && src_owner[r.src] < NCPU)
                    act = (src_owner[r.src] == {5'd0, r.caller}) ? ACT_LOCAL : ACT_IPI;
            end
        end
        rep.next_ns = q_next[q];
        rep.first_src = q_first[q];
        rep.empty = (q_next[q] == DL_NONE);
        rep.act = act;
        rep.tgt = q;
        return rep;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $time);
        mismatches++;
    endtask

    task automatic send_req(input t_tq_req r, input logic typed, input t_tq_report typed_rep);
        int         gap;
        t_tq_report want;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.fn;
        s_tdata <= {4'd0, r.caller, r.cpu, r.kind, r.dl, r.src};
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
        want = queue_report_for(r);
        awaited_reports.push_back(typed ? typed_rep : want);
        @(negedge i_clk);
    endtask

    task automatic set_cpu_count(input logic [3:0] v);
        s_tvalid <= 1'b0;
        while (awaited_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cpus_present = v;
    endtask

    // stimulus
    initial begin
        t_tq_req     r;
        int          pick;
        int          sub;
        logic [4:0]  s;
        logic [3:0]  counts [5];
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        no_gaps = 1'b0;
        hold_off = 1'b0;
        mismatches = 0;
        counts = '{4'd8, 4'd1, 4'd5, 4'd3, 4'd8};
        for (int i = 0; i < NSRC; i++) begin
            src_dl[i] = '0;
            src_owner[i] = '0;
            src_kind[i] = '0;
            src_on[i] = 1'b0;
            src_bound[i] = 1'b0;
        end
        for (int i = 0; i < NCPU; i++) begin
            q_next[i] = DL_NONE;
            q_first[i] = '0;
        end
        cpus_present = 4'd1;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (STEPS[i]) begin
            if (STEPS[i].req.fn == FN_INIT)
                src_bound[STEPS[i].req.src] = 1'b1;
            send_req(STEPS[i].req, STEPS[i].typed, STEPS[i].rep);
        end

        for (int ph = 0; ph < 5; ph++) begin
            set_cpu_count(counts[ph]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                no_gaps = ((k / 48) % 5 == 4);
                if (ph == 0 && k == 100)
                    hold_off = 1'b1;
                pick = $urandom_range(0, 99);
                r.dl = {$urandom, $urandom};
                r.kind = 4'($urandom);
                r.caller = 3'($urandom);
                r.src = 5'($urandom);
                r.cpu = 8'($urandom_range(0, NCPU - 1));
                if (pick < 15) begin
                    r.fn = FN_INIT;
                    if ($urandom_range(0, 9) == 0)
                        r.cpu = 8'($urandom_range(NCPU, 255));
                    src_bound[r.src] = 1'b1;
                end else if (pick < 82) begin
                    // only sources that have been bound get updated
                    r.fn = FN_UPDATE;
                    s = r.src;
                    while (!src_bound[s]) s = s + 5'd1;
                    r.src = s;
                    sub = $urandom_range(0, 99);
                    if (sub < 40)
                        r.dl = 64'($urandom_range(0, 15)) * 64'd1000;
                    else if (sub < 55)
                        r.dl = DL_NONE;
                    else if (sub < 65)
                        r.dl = src_dl[s];
                    else if (sub < 70)
                        r.dl = DL_NONE - 64'($urandom_range(1, 3));
                    if ($urandom_range(0, 1) == 1)
                        r.caller = src_owner[s][2:0];
                end else begin
                    r.fn = (pick < 84) ? FN_SPARE : FN_QUERY;
                    if ($urandom_range(0, 7) == 0)
                        r.cpu = 8'($urandom);
                end
                send_req(r, 1'b0, NO_REP);
            end
        end

        s_tvalid <= 1'b0;
        while (awaited_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // result side
    initial begin
        int         stall;
        t_tq_report want;
        t_tq_report got;
        m_tready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (hold_off) begin
                // long hold so the block backs up and drops tready
                hold_off = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            stall = no_gaps ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_tvalid && m_tready));
            got.next_ns = m_tdata[63:0];
            got.first_src = m_tdata[OUT_ES_LSB +: 5];
            got.empty = m_tdata[OUT_EMPTY_BIT];
            got.tgt = m_tdata[OUT_TGT_LSB +: 3];
            got.act = m_tuser;
            if (awaited_reports.size() == 0) begin
                report_mismatch("unrequested beat", got.next_ns, DL_NONE);
            end else begin
                want = awaited_reports.pop_front();
                if (got.next_ns !== want.next_ns)
                    report_mismatch("next_ns", got.next_ns, want.next_ns);
                if (got.first_src !== want.first_src)
                    report_mismatch("earliest_source", 64'(got.first_src), 64'(want.first_src));
                if (got.empty !== want.empty)
                    report_mismatch("queue_empty", 64'(got.empty), 64'(want.empty));
                if (got.act !== want.act)
                    report_mismatch("action", 64'(got.act), 64'(want.act));
                if (got.tgt !== want.tgt)
                    report_mismatch("target_cpu", 64'(got.tgt), 64'(want.tgt));
            end
            @(negedge i_clk);
        end
    end

    // watchdog on cycles with no beat on either side
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
